@@ rtl/cst_pkg.sv @@
// ----------------------------------------------------------------------------
// cst_pkg
// Shared types and constants of the character stream tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none

package cst_pkg;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_IDENT = 2'd1,
    MODE_NUM   = 2'd2,
    MODE_OP    = 2'd3
  } mode_e;

  typedef enum logic [3:0] {
    KIND_KEYWORD = 4'd0,
    KIND_IDENT   = 4'd1,
    KIND_LITERAL = 4'd2,
    KIND_LPAREN  = 4'd3,
    KIND_RPAREN  = 4'd4,
    KIND_ADD     = 4'd5,
    KIND_SUB     = 4'd6,
    KIND_MUL     = 4'd7,
    KIND_DIV     = 4'd8,
    KIND_ASSIGN  = 4'd9,
    KIND_COMMA   = 4'd10,
    KIND_UNKNOWN = 4'd11,
    KIND_EOF     = 4'd12
  } kind_e;

  // An operator code of zero means the byte is not an operator.
  localparam logic [3:0] OP_NONE = 4'd0;

  localparam logic [7:0]  CH_NEWLINE    = 8'h0A;
  localparam logic [7:0]  CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0]  MAX_LEX_RESET = 8'd100;
  localparam logic [15:0] LINE_RESET    = 16'd1;
  localparam logic [15:0] LINE_MAX      = 16'hFFFF;
  localparam logic [7:0]  LEN_OUT_MAX   = 8'hFF;

  // Result queue: room for two results of one item plus two in flight.
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned PTR_W      = 2;
  localparam int unsigned CNT_W      = 3;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  length;
    logic [15:0] line;
    logic        too_long;
    logic        last;
  } result_t;

  function automatic logic [7:0] kw_char(input logic [1:0] idx);
    logic [7:0] ch;
    unique case (idx)
      2'd0:    ch = "i";
      2'd1:    ch = "n";
      2'd2:    ch = "t";
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [3:0] op_code(input logic [7:0] c);
    logic [3:0] code;
    unique case (c)
      "(":     code = KIND_LPAREN;
      ")":     code = KIND_RPAREN;
      "+":     code = KIND_ADD;
      "-":     code = KIND_SUB;
      "*":     code = KIND_MUL;
      "/":     code = KIND_DIV;
      "=":     code = KIND_ASSIGN;
      ",":     code = KIND_COMMA;
      default: code = OP_NONE;
    endcase
    return code;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'd32) || ((c >= 8'd9) && (c <= 8'd13));
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

endpackage

`default_nettype wire

@@ rtl/cst_in_if.sv @@
// ----------------------------------------------------------------------------
// cst_in_if
// Character input channel: one source byte or an end-of-input mark.
// ----------------------------------------------------------------------------
`default_nettype none

interface cst_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       end_of_input;

  modport source (output valid, output char_in, output end_of_input, input ready);
  modport sink   (input valid, input char_in, input end_of_input, output ready);
endinterface

`default_nettype wire

@@ rtl/cst_out_if.sv @@
// ----------------------------------------------------------------------------
// cst_out_if
// Token output channel: one token per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface cst_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  token_kind;
  logic [7:0]  lexeme_length;
  logic [15:0] token_line;
  logic        too_long;
  logic        last;

  modport source (output valid, output token_kind, output lexeme_length,
                  output token_line, output too_long, output last, input ready);
  modport sink   (input valid, input token_kind, input lexeme_length,
                  input token_line, input too_long, input last, output ready);
endinterface

`default_nettype wire

@@ rtl/cst_cfg_if.sv @@
// ----------------------------------------------------------------------------
// cst_cfg_if
// Configuration write channel carrying the max_lexeme register value.
// ----------------------------------------------------------------------------
`default_nettype none

interface cst_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] max_lexeme;

  modport source (output valid, output max_lexeme, input ready);
  modport sink   (input valid, input max_lexeme, output ready);
endinterface

`default_nettype wire

@@ rtl/char_stream_tokenizer_top.sv @@
// ----------------------------------------------------------------------------
// char_stream_tokenizer_top
// Byte-at-a-time lexer: classifies each character, tracks the open token and
// emits keyword, identifier, literal, operator, unknown and end-of-file tokens.
// ----------------------------------------------------------------------------
//  channel  | direction | transaction carries
//  ---------+-----------+------------------------------------------------------
//  char_i   | in        | char_in, end_of_input
//  token_o  | out       | token_kind, lexeme_length, token_line, too_long, last
//  cfg_i    | in        | max_lexeme (always ready)
//
// Every accepted character updates the token state in the same cycle and
// pushes zero, one or two tokens into a four-entry result queue. char_i takes
// a new character every cycle while the queue has room for two tokens; a
// character that ends a token and is itself unknown, or an end-of-input mark
// that closes an open token, yields two tokens. Each token is registered in
// the queue and appears on token_o once the tokens ahead of it are taken.
// Reset empties the queue, closes any token and sets the line counter to one.
// ----------------------------------------------------------------------------
`default_nettype none

module char_stream_tokenizer_top
  import cst_pkg::*;
#(
  parameter int unsigned LENGTH_BITS = 8
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  cst_in_if.sink      char_i,
  cst_out_if.source   token_o,
  cst_cfg_if.sink     cfg_i
);

  localparam int unsigned CmpW = (LENGTH_BITS > 8) ? LENGTH_BITS : 8;
  localparam logic [LENGTH_BITS-1:0] LenCap = {LENGTH_BITS{1'b1}};
  localparam logic [CmpW-1:0] LenOutMaxW = CmpW'(LEN_OUT_MAX);

  // Configuration register.
  logic [7:0] max_lex_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_lex_q <= MAX_LEX_RESET;
    end else if (cfg_i.valid) begin
      max_lex_q <= cfg_i.max_lexeme;
    end
  end

  // Token state.
  mode_e                  mode_q, mode_d;
  logic [LENGTH_BITS-1:0] count_q, count_d;
  logic [1:0]             prog_q, prog_d;
  logic                   alive_q, alive_d;
  logic [3:0]             first_op_q, first_op_d;
  logic [15:0]            line_q, line_d;

  // Result queue.
  result_t          fifo_q [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] fill_q, fill_d;

  logic       in_acc, out_acc;
  logic [7:0] ch;
  logic       eoi;
  logic       c_space, c_letter, c_digit, c_word, c_op, c_start_id;
  logic [3:0] c_opcode;
  logic       cont, flush_v, unk_v, eof_v, kw_match;
  logic [CmpW-1:0] len_ext;
  result_t    flush_r, extra_r, res_a, res_b;
  logic [1:0] push_n;

  assign in_acc  = char_i.valid && char_i.ready;
  assign out_acc = token_o.valid && token_o.ready;
  assign ch      = char_i.char_in;
  assign eoi     = char_i.end_of_input;

  // Room for the two tokens one character can cause.
  assign char_i.ready = (fill_q <= CNT_W'(FIFO_DEPTH - 2));

  always_comb begin
    c_opcode   = op_code(ch);
    c_space    = is_space(ch);
    c_letter   = is_letter(ch);
    c_digit    = is_digit(ch);
    c_op       = (c_opcode != OP_NONE);
    c_start_id = c_letter || (ch == CH_UNDERSCORE);
    c_word     = c_start_id || c_digit;

    cont = !eoi && (((mode_q == MODE_IDENT) && c_word) ||
                    ((mode_q == MODE_NUM) && c_digit) ||
                    ((mode_q == MODE_OP) && c_op));
    flush_v = (mode_q != MODE_IDLE) && !cont;
    eof_v   = eoi;
    unk_v   = !eoi && !c_space && !c_word && !c_op;

    // The newline counts before the token it terminates is reported.
    line_d = line_q;
    if (!eoi && (ch == CH_NEWLINE) && (line_q != LINE_MAX)) begin
      line_d = line_q + 16'd1;
    end

    // Closing token.
    len_ext = CmpW'(count_q);
    unique case (mode_q)
      MODE_IDENT: flush_r.kind = (alive_q && (prog_q == 2'd3) &&
                                  (count_q == LENGTH_BITS'(3))) ? KIND_KEYWORD : KIND_IDENT;
      MODE_NUM:   flush_r.kind = KIND_LITERAL;
      default:    flush_r.kind = (count_q == LENGTH_BITS'(1)) ? kind_e'(first_op_q)
                                                              : KIND_UNKNOWN;
    endcase
    flush_r.length   = (len_ext > LenOutMaxW) ? LEN_OUT_MAX : len_ext[7:0];
    flush_r.line     = line_d;
    flush_r.too_long = (len_ext >= CmpW'(max_lex_q));
    flush_r.last     = !(eof_v || unk_v);

    // End-of-file or unknown byte token.
    if (eof_v) begin
      extra_r.kind     = KIND_EOF;
      extra_r.length   = 8'd0;
      extra_r.too_long = 1'b0;
    end else begin
      extra_r.kind     = KIND_UNKNOWN;
      extra_r.length   = 8'd1;
      extra_r.too_long = (max_lex_q <= 8'd1);
    end
    extra_r.line = line_d;
    extra_r.last = 1'b1;

    if (flush_v) begin
      res_a = flush_r;
      res_b = extra_r;
    end else begin
      res_a = extra_r;
      res_b = extra_r;
    end
    push_n = in_acc ? ({1'b0, flush_v} + {1'b0, eof_v || unk_v}) : 2'd0;

    // Keyword tracking for a continuing identifier.
    kw_match = alive_q && (count_q < LENGTH_BITS'(3)) &&
               (prog_q == count_q[1:0]) && (ch == kw_char(count_q[1:0]));

    mode_d     = mode_q;
    count_d    = count_q;
    prog_d     = prog_q;
    alive_d    = alive_q;
    first_op_d = first_op_q;
    if (in_acc) begin
      if (eoi) begin
        mode_d = MODE_IDLE;
      end else if (cont) begin
        if (kw_match) begin
          prog_d = prog_q + 2'd1;
        end else begin
          alive_d = 1'b0;
        end
        if (count_q != LenCap) begin
          count_d = count_q + LENGTH_BITS'(1);
        end
      end else begin
        mode_d = MODE_IDLE;
        if (c_start_id || c_digit || c_op) begin
          if (c_start_id) begin
            mode_d = MODE_IDENT;
          end else if (c_digit) begin
            mode_d = MODE_NUM;
          end else begin
            mode_d = MODE_OP;
          end
          count_d    = LENGTH_BITS'(1);
          prog_d     = (ch == kw_char(2'd0)) ? 2'd1 : 2'd0;
          alive_d    = (ch == kw_char(2'd0));
          first_op_d = c_opcode;
        end
      end
    end

    fill_d = fill_q + CNT_W'(push_n) - CNT_W'(out_acc);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_IDLE;
      count_q    <= '0;
      prog_q     <= 2'd0;
      alive_q    <= 1'b1;
      first_op_q <= OP_NONE;
      line_q     <= LINE_RESET;
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      fill_q     <= '0;
    end else begin
      mode_q     <= mode_d;
      count_q    <= count_d;
      prog_q     <= prog_d;
      alive_q    <= alive_d;
      first_op_q <= first_op_d;
      if (in_acc) begin
        line_q <= line_d;
      end
      wr_ptr_q <= wr_ptr_q + PTR_W'(push_n);
      rd_ptr_q <= rd_ptr_q + PTR_W'(out_acc);
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_n != 2'd0) begin
      fifo_q[wr_ptr_q] <= res_a;
    end
    if (push_n == 2'd2) begin
      fifo_q[wr_ptr_q + PTR_W'(1)] <= res_b;
    end
  end

  assign token_o.valid         = (fill_q != '0);
  assign token_o.token_kind    = fifo_q[rd_ptr_q].kind;
  assign token_o.lexeme_length = fifo_q[rd_ptr_q].length;
  assign token_o.token_line    = fifo_q[rd_ptr_q].line;
  assign token_o.too_long      = fifo_q[rd_ptr_q].too_long;
  assign token_o.last          = fifo_q[rd_ptr_q].last;

`ifndef ASSERT_OFF
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CNT_W'(FIFO_DEPTH))
    else $error("result queue overfilled");

  a_eof_queued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && eoi) |=> (fill_q != '0))
    else $error("end of input produced no token");

  a_eof_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && eoi) |=> (mode_q == MODE_IDLE))
    else $error("token left open after end of input");

  a_line_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    line_q != 16'd0)
    else $error("line counter wrapped");
`endif

endmodule

`default_nettype wire
